/* hdl/mmlc_pkg.sv */
// shared types and constants for the multi-mode led channel controller
// no dependencies; used by the lane, output stage, top level, checker and bench
`timescale 1ns / 1ps

package mmlc_pkg;

    // fixed field widths
    localparam int MAX_LANES   = 4;
    localparam int COUNT_W     = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_SELECT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_LEVELS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_COUNTS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_COUNTS     = 3'd3;

    // lane mode codes
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PWM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd3;

    // per-lane slice of the configuration registers
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               init_level;
        logic [COUNT_W-1:0] on_count;
        logic [COUNT_W-1:0] off_count;
    } t_lane_cfg;

endpackage

/* hdl/mmlc_lane.sv */
// one led lane: init/running/halted phase machine, switch history and pwm counter
// depends on mmlc_pkg
`timescale 1ns / 1ps

module mmlc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  mmlc_pkg::t_lane_cfg i_cfg,
    input  logic               i_switch,
    input  logic               i_halt,
    output logic               o_level_next
);

    localparam logic [1:0] PHASE_INIT = 2'd0;
    localparam logic [1:0] PHASE_RUN  = 2'd1;
    localparam logic [1:0] PHASE_HALT = 2'd2;

    logic [1:0]                     r_phase, n_phase;
    logic                           r_level, n_level;
    logic [1:0]                     r_hist,  n_hist;
    logic [mmlc_pkg::COUNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        n_hist  = r_hist;
        n_count = r_count;
        unique case (r_phase)
            PHASE_INIT: begin
                n_level = i_cfg.init_level;
                n_hist  = 2'b11;
                n_count = '0;
                n_phase = PHASE_RUN;
            end
            PHASE_RUN: begin
                if (i_halt) begin
                    n_phase = PHASE_HALT;
                end else begin
                    case (i_cfg.mode)
                        mmlc_pkg::MODE_SWITCH: begin
                            n_hist = {r_hist[0], i_switch};
                            // rising edge: previous low, newest high
                            if (n_hist == 2'b01) begin
                                n_level = ~r_level;
                            end
                        end
                        mmlc_pkg::MODE_PWM: begin
                            // a flip clears the counter, then it advances
                            if (r_level && (r_count == i_cfg.on_count)) begin
                                n_level = 1'b0;
                                n_count = mmlc_pkg::COUNT_W'(1);
                            end else if (!r_level && (r_count == i_cfg.off_count)) begin
                                n_level = 1'b1;
                                n_count = mmlc_pkg::COUNT_W'(1);
                            end else begin
                                n_count = r_count + mmlc_pkg::COUNT_W'(1);
                            end
                        end
                        default: begin
                            // constant and hold keep the level
                        end
                    endcase
                end
            end
            PHASE_HALT: begin
                if (!i_halt) begin
                    n_phase = PHASE_INIT;
                end
            end
            default: begin
                // unused phase code: lane stays put
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_INIT;
            r_level <= 1'b0;
            r_hist  <= 2'b00;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_level <= n_level;
            r_hist  <= n_hist;
            r_count <= n_count;
        end
    end

    assign o_level_next = n_level;

endmodule

/* hdl/mmlc_merge.sv */
// merging stage: gathers lane levels into the result beat and holds it in an output register
// depends on mmlc_pkg
`timescale 1ns / 1ps

module mmlc_merge #(
    parameter int LED_LANES = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [LED_LANES-1:0]           i_lane_levels,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [mmlc_pkg::MAX_LANES-1:0] o_led_levels,
    output logic                           o_busy
);

    logic                           r_valid, n_valid;
    logic [mmlc_pkg::MAX_LANES-1:0] r_levels;

    // absent lanes read as zero
    logic [mmlc_pkg::MAX_LANES-1:0] w_merged;
    assign w_merged = mmlc_pkg::MAX_LANES'(i_lane_levels);

    // register full and not being taken this cycle
    assign o_busy = r_valid && i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_levels <= w_merged;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_led_levels = r_levels;

endmodule

/* hdl/multi_mode_led_channel_controller.sv */
// top level of the multi-mode led channel controller: config registers, lanes, output stage
// depends on mmlc_pkg, mmlc_lane and mmlc_merge
`timescale 1ns / 1ps

// usage
//   input channel (i_in_valid / o_in_stall): one beat is one tick, carrying a
//   switch level and a halt request bit per lane
//   output channel (o_out_valid / i_out_stall): one beat per tick with the
//   level of every lane after that tick; bits of absent lanes are zero
//   config channel (i_cfg_valid / o_cfg_ready): index 0 mode select, 1 initial
//   levels, 2 on counts, 3 off counts; other indexes are ignored; always ready,
//   write only while no tick is in flight
//   result beat: registered, appears in the cycle after the input beat is taken
//   throughput: one tick per cycle while the output is not stalled; every lane
//   updates its phase, level, switch history and 16-bit counter on each tick
//   stall: the output register holds its beat while i_out_stall is high and
//   o_in_stall rises, so no tick is taken until the beat leaves; a new tick
//   is taken in the same cycle the held beat is taken
//   reset: synchronous, active low; config registers clear to zero, every
//   lane goes to its init phase with level, history and counter at zero,
//   and the output register empties

module multi_mode_led_channel_controller #(
    parameter int LED_LANES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mmlc_pkg::MAX_LANES-1:0]    i_switch_inputs,
    input  logic [mmlc_pkg::MAX_LANES-1:0]    i_halt_requests,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mmlc_pkg::MAX_LANES-1:0]    o_led_levels,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmlc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mmlc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [2*mmlc_pkg::MAX_LANES-1:0]                r_mode_select;
    logic [mmlc_pkg::MAX_LANES-1:0]                  r_initial_levels;
    logic [mmlc_pkg::COUNT_W*mmlc_pkg::MAX_LANES-1:0] r_on_counts;
    logic [mmlc_pkg::COUNT_W*mmlc_pkg::MAX_LANES-1:0] r_off_counts;

    logic w_cfg_write;
    logic w_step;
    logic w_busy;

    logic [LED_LANES-1:0] w_lane_levels;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_select    <= '0;
            r_initial_levels <= '0;
            r_on_counts      <= '0;
            r_off_counts     <= '0;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                mmlc_pkg::REG_MODE_SELECT: begin
                    r_mode_select <= i_cfg_data[2*mmlc_pkg::MAX_LANES-1:0];
                end
                mmlc_pkg::REG_INITIAL_LEVELS: begin
                    r_initial_levels <= i_cfg_data[mmlc_pkg::MAX_LANES-1:0];
                end
                mmlc_pkg::REG_ON_COUNTS: begin
                    r_on_counts <= i_cfg_data;
                end
                mmlc_pkg::REG_OFF_COUNTS: begin
                    r_off_counts <= i_cfg_data;
                end
                default: begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    // a tick is taken whenever the output register can take its result
    assign o_in_stall = w_busy;
    assign w_step     = i_in_valid && !w_busy;

    // one lane core per led, all stepping on the same tick
    for (genvar k = 0; k < LED_LANES; k++) begin : g_lane
        mmlc_pkg::t_lane_cfg w_cfg;

        assign w_cfg.mode       = r_mode_select[2*k +: 2];
        assign w_cfg.init_level = r_initial_levels[k];
        assign w_cfg.on_count   = r_on_counts[mmlc_pkg::COUNT_W*k +: mmlc_pkg::COUNT_W];
        assign w_cfg.off_count  = r_off_counts[mmlc_pkg::COUNT_W*k +: mmlc_pkg::COUNT_W];

        mmlc_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (w_step),
            .i_cfg        (w_cfg),
            .i_switch     (i_switch_inputs[k]),
            .i_halt       (i_halt_requests[k]),
            .o_level_next (w_lane_levels[k])
        );
    end

    // merge lane levels into the result beat
    mmlc_merge #(
        .LED_LANES (LED_LANES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_step),
        .i_lane_levels (w_lane_levels),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_led_levels  (o_led_levels),
        .o_busy        (w_busy)
    );

endmodule

/* hdl/mmlc_checker.sv */
// port-level checks for the multi-mode led channel controller, bound to the top level
// depends on mmlc_pkg and multi_mode_led_channel_controller
`timescale 1ns / 1ps

module mmlc_checker #(
    parameter int LED_LANES = 4
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [mmlc_pkg::MAX_LANES-1:0] o_led_levels
);

    localparam logic [mmlc_pkg::MAX_LANES-1:0] LANE_MASK =
        mmlc_pkg::MAX_LANES'((1 << LED_LANES) - 1);

    // every accepted tick yields a result beat in the next cycle
    a_tick_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted tick produced no result beat");

    // a held, stalled beat blocks new ticks
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("tick taken while result beat stalled");

    // an empty output register never refuses a tick
    a_empty_takes_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    // absent lanes drive zero in every valid result beat
    a_absent_lanes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_led_levels & ~LANE_MASK) == '0))
        else $error("absent lane drives a level");

    // stalled beat holds its payload
    a_stalled_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_led_levels)))
        else $error("stalled result beat changed");

endmodule

bind multi_mode_led_channel_controller mmlc_checker #(
    .LED_LANES (LED_LANES)
) u_mmlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_led_levels (o_led_levels)
);

/* bench/tb_multi_mode_led_channel_controller.sv */
// testbench for the multi-mode led channel controller: random and directed ticks,
// an in-bench lane predictor and a scoreboard on the led levels
// depends on mmlc_pkg and multi_mode_led_channel_controller
`timescale 1ns / 1ps

module tb_multi_mode_led_channel_controller;

    localparam int LANES         = mmlc_pkg::MAX_LANES;
    localparam int IDLE_LIMIT    = 5000;   // cycles with no beat on any channel
    localparam int SQUEEZE_LEN   = 60;     // long receiver hold-off, in cycles
    localparam int SQUEEZE_AT_A  = 300;
    localparam int SQUEEZE_AT_B  = 900;
    localparam int PHASE_TICKS   = 148;
    localparam int RANDOM_PHASES = 8;

    // index that no register answers to
    localparam logic [mmlc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd5;

    typedef enum logic [1:0] {
        LANE_INIT = 2'd0,
        LANE_RUN  = 2'd1,
        LANE_HALT = 2'd2
    } t_lane_phase;

    // one tick as offered on the input channel
    typedef struct packed {
        logic [mmlc_pkg::MAX_LANES-1:0] sw;
        logic [mmlc_pkg::MAX_LANES-1:0] halt;
    } t_tick;

    // block ports
    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [mmlc_pkg::MAX_LANES-1:0]       i_switch_inputs = '0;
    logic [mmlc_pkg::MAX_LANES-1:0]       i_halt_requests = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic [mmlc_pkg::MAX_LANES-1:0]       o_led_levels;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [mmlc_pkg::CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [mmlc_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;

    // stimulus and scoreboard
    t_tick                                pending_ticks[$];
    logic [mmlc_pkg::MAX_LANES-1:0]       expected_levels[$];
    logic [mmlc_pkg::MAX_LANES-1:0]       want_levels;
    t_tick                                next_tick;
    int                                   mismatches = 0;
    int                                   results_seen = 0;
    int                                   in_gap = 0;
    int                                   out_gap = 0;
    int                                   squeeze_left = 0;
    int                                   idle_cycles = 0;
    bit                                   quiet_in = 1'b0;
    bit                                   quiet_out = 1'b0;

    // register copies as the block should hold them
    logic [7:0]                           mode_reg = '0;
    logic [mmlc_pkg::MAX_LANES-1:0]       init_reg = '0;
    logic [63:0]                          on_reg = '0;
    logic [63:0]                          off_reg = '0;

    // lane state of the predictor
    t_lane_phase                          lane_phase[LANES] = '{default: LANE_INIT};
    logic                                 lane_level[LANES] = '{default: 1'b0};
    logic [1:0]                           lane_hist[LANES] = '{default: 2'b00};
    logic [mmlc_pkg::COUNT_W-1:0]         lane_count[LANES] = '{default: '0};

    multi_mode_led_channel_controller #(
        .LED_LANES(LANES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_switch_inputs(i_switch_inputs),
        .i_halt_requests(i_halt_requests),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_led_levels   (o_led_levels),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance every lane by one tick and return the levels it drives afterwards
    function automatic logic [mmlc_pkg::MAX_LANES-1:0] advance_lanes(
        input logic [mmlc_pkg::MAX_LANES-1:0] sw,
        input logic [mmlc_pkg::MAX_LANES-1:0] halt);
        logic [mmlc_pkg::MAX_LANES-1:0] levels;
        logic [1:0]                     mode;
        logic [mmlc_pkg::COUNT_W-1:0]   on_c;
        logic [mmlc_pkg::COUNT_W-1:0]   off_c;
        levels = '0;
        for (int k = 0; k < LANES; k++) begin
            mode  = mode_reg[2*k +: 2];
            on_c  = on_reg[16*k +: 16];
            off_c = off_reg[16*k +: 16];
            case (lane_phase[k])
                LANE_INIT: begin
                    lane_level[k] = init_reg[k];
                    lane_hist[k]  = 2'b11;
                    lane_count[k] = '0;
                    lane_phase[k] = LANE_RUN;
                end
                LANE_RUN: begin
                    if (halt[k]) begin
                        lane_phase[k] = LANE_HALT;
                    end else if (mode == mmlc_pkg::MODE_SWITCH) begin
                        // rising edge shows up as previous 0, newest 1
                        lane_hist[k] = {lane_hist[k][0], sw[k]};
                        if (lane_hist[k] == 2'b01)
                            lane_level[k] = ~lane_level[k];
                    end else if (mode == mmlc_pkg::MODE_PWM) begin
                        if (lane_level[k] && lane_count[k] == on_c) begin
                            lane_level[k] = 1'b0;
                            lane_count[k] = '0;
                        end else if (!lane_level[k] && lane_count[k] == off_c) begin
                            lane_level[k] = 1'b1;
                            lane_count[k] = '0;
                        end
                        // 16-bit counter, wraps from all ones to zero
                        lane_count[k] = lane_count[k] + 1'b1;
                    end
                    // constant and hold keep the level
                end
                LANE_HALT: begin
                    if (!halt[k])
                        lane_phase[k] = LANE_INIT;
                end
                default: ;
            endcase
            levels[k] = lane_level[k];
        end
        return levels;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // per-lane counts: small values dominate so pwm flips often, extremes mixed in
    function automatic logic [63:0] pick_counts();
        logic [63:0] counts;
        int          r;
        for (int k = 0; k < LANES; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                counts[16*k +: 16] = 16'($urandom_range(0, 6));
            else if (r < 70)
                counts[16*k +: 16] = 16'h0000;
            else if (r < 85)
                counts[16*k +: 16] = 16'hFFFF;
            else
                counts[16*k +: 16] = 16'($urandom);
        end
        return counts;
    endfunction

    task automatic queue_tick(input logic [mmlc_pkg::MAX_LANES-1:0] s,
                              input logic [mmlc_pkg::MAX_LANES-1:0] h);
        t_tick t;
        t.sw   = s;
        t.halt = h;
        pending_ticks.push_back(t);
    endtask

    // switch levels mostly persist so edges come at random spacing; halts are rare
    // so lanes run deep, with whole-bank halt bursts and some fully random noise
    task automatic queue_random_ticks(input int count, input bit allow_halt);
        logic [mmlc_pkg::MAX_LANES-1:0] sw;
        logic [mmlc_pkg::MAX_LANES-1:0] halt;
        int                             burst;
        sw    = mmlc_pkg::MAX_LANES'($urandom);
        burst = 0;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < LANES; k++)
                if ($urandom_range(0, 99) < 30)
                    sw[k] = ~sw[k];
            halt = '0;
            if (allow_halt) begin
                if (burst > 0) begin
                    burst--;
                    halt = '1;
                end else if ($urandom_range(0, 99) < 2) begin
                    burst = $urandom_range(1, 4);
                end
                for (int k = 0; k < LANES; k++)
                    if ($urandom_range(0, 99) < 4)
                        halt[k] = 1'b1;
                if ($urandom_range(0, 99) < 5) begin
                    sw   = mmlc_pkg::MAX_LANES'($urandom);
                    halt = mmlc_pkg::MAX_LANES'($urandom);
                end
            end
            queue_tick(sw, halt);
        end
    endtask

    // one register write; the local copy follows at the accepting edge
    task automatic write_reg(input logic [mmlc_pkg::CFG_INDEX_W-1:0] index,
                             input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            mmlc_pkg::REG_MODE_SELECT:    mode_reg = value[7:0];
            mmlc_pkg::REG_INITIAL_LEVELS: init_reg = value[mmlc_pkg::MAX_LANES-1:0];
            mmlc_pkg::REG_ON_COUNTS:      on_reg   = value;
            mmlc_pkg::REG_OFF_COUNTS:     off_reg  = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // block is idle once no tick is queued, offered or awaiting its result beat
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || o_out_valid ||
               expected_levels.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // driver: offers queued ticks, holds a stalled beat, predicts each taken beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_levels.push_back(advance_lanes(i_switch_inputs, i_halt_requests));
            if (i_in_valid && o_in_stall) begin
                // stalled beat stays as it is
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                next_tick = pending_ticks.pop_front();
                i_switch_inputs <= next_tick.sw;
                i_halt_requests <= next_tick.halt;
                i_in_valid      <= 1'b1;
                in_gap = quiet_in ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result beat against the oldest prediction, drives stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_levels.size() == 0) begin
                    $display("%0t: led_levels beat %b with no tick outstanding",
                             $time, o_led_levels);
                    mismatches++;
                end else begin
                    want_levels = expected_levels.pop_front();
                    if (o_led_levels !== want_levels) begin
                        $display("%0t: led_levels expected %b actual %b",
                                 $time, want_levels, o_led_levels);
                        mismatches++;
                    end
                end
                results_seen++;
                // long hold-off so the output register fills and the input stalls
                if (results_seen == SQUEEZE_AT_A || results_seen == SQUEEZE_AT_B)
                    squeeze_left = SQUEEZE_LEN;
            end
            if (squeeze_left > 0) begin
                squeeze_left--;
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                out_gap = quiet_out ? 0 : pick_gap();
            end
        end
    end

    // watchdog: too long without a beat on any channel means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: every lane constant at level zero
        queue_tick(4'h0, 4'h0);
        queue_tick(4'hF, 4'hF);
        queue_tick(4'hF, 4'h0);
        queue_tick(4'h0, 4'h0);
        wait_drained();

        // one lane per mode: lane 0 constant, 1 switch, 2 pwm, 3 hold
        write_reg(mmlc_pkg::REG_MODE_SELECT,
                  64'({mmlc_pkg::MODE_HOLD, mmlc_pkg::MODE_PWM,
                       mmlc_pkg::MODE_SWITCH, mmlc_pkg::MODE_CONST}));
        write_reg(mmlc_pkg::REG_INITIAL_LEVELS, 64'hA);
        write_reg(mmlc_pkg::REG_ON_COUNTS, 64'hFFFF_0001_0000_0002);
        write_reg(mmlc_pkg::REG_OFF_COUNTS, 64'h0000_0000_FFFF_0003);
        // unknown index leaves every register alone
        write_reg(REG_UNUSED, '1);

        // halt and release all lanes so they load the new initial levels
        queue_tick(4'h0, 4'hF);
        queue_tick(4'h0, 4'h0);
        queue_tick(4'h0, 4'h0);
        // switch lane sees high, falling, rising, held high, then falling
        queue_tick(4'h2, 4'h0);
        queue_tick(4'h0, 4'h0);
        queue_tick(4'h2, 4'h0);
        queue_tick(4'h2, 4'h0);
        queue_tick(4'hF, 4'h0);
        queue_tick(4'h0, 4'h0);
        // halting pwm lane keeps driving its last level, then restarts
        queue_tick(4'h0, 4'h4);
        queue_tick(4'hF, 4'h4);
        queue_tick(4'h0, 4'h0);
        queue_tick(4'h0, 4'h0);
        queue_tick(4'hF, 4'h0);
        // single-lane halts on switch and hold lanes
        queue_tick(4'h0, 4'h2);
        queue_tick(4'h0, 4'h8);
        queue_tick(4'hA, 4'h0);
        queue_tick(4'h5, 4'h0);
        queue_tick(4'hF, 4'hF);
        queue_tick(4'h0, 4'h0);
        queue_tick(4'h0, 4'h0);
        wait_drained();

        // random phases, each under its own settings including the extremes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet_in  = (p % 3 == 2);
            quiet_out = (p % 4 == 3);
            case (p)
                0:       write_reg(mmlc_pkg::REG_MODE_SELECT, 64'hFF);
                1:       write_reg(mmlc_pkg::REG_MODE_SELECT, 64'hAA);
                2:       write_reg(mmlc_pkg::REG_MODE_SELECT, 64'h55);
                3:       write_reg(mmlc_pkg::REG_MODE_SELECT, 64'h00);
                5:       write_reg(mmlc_pkg::REG_MODE_SELECT, 64'hAA);
                default: write_reg(mmlc_pkg::REG_MODE_SELECT,
                                   64'($urandom_range(0, 255)));
            endcase
            case (p)
                0:       write_reg(mmlc_pkg::REG_INITIAL_LEVELS, 64'hF);
                3:       write_reg(mmlc_pkg::REG_INITIAL_LEVELS, 64'h0);
                default: write_reg(mmlc_pkg::REG_INITIAL_LEVELS,
                                   64'($urandom_range(0, 15)));
            endcase
            if (p == 3) begin
                write_reg(mmlc_pkg::REG_ON_COUNTS, '0);
                write_reg(mmlc_pkg::REG_OFF_COUNTS, '0);
            end else if (p == 5) begin
                write_reg(mmlc_pkg::REG_ON_COUNTS, '1);
                write_reg(mmlc_pkg::REG_OFF_COUNTS, '1);
            end else begin
                write_reg(mmlc_pkg::REG_ON_COUNTS, pick_counts());
                write_reg(mmlc_pkg::REG_OFF_COUNTS, pick_counts());
            end
            // restart every lane, then run
            queue_tick(mmlc_pkg::MAX_LANES'($urandom), 4'hF);
            queue_tick(mmlc_pkg::MAX_LANES'($urandom), 4'h0);
            queue_random_ticks(PHASE_TICKS, 1'b1);
            wait_drained();
        end

        if (mismatches == 0 && expected_levels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
hdl/mmlc_pkg.sv
hdl/mmlc_lane.sv
hdl/mmlc_merge.sv
hdl/multi_mode_led_channel_controller.sv
hdl/mmlc_checker.sv
bench/tb_multi_mode_led_channel_controller.sv
